// ===== hw/rtl/lu_linear_solver_assert.svh =====
// ----------------------------------------------------------------------------
// lu_linear_solver_assert.svh
// Assertion macros for the LU solver checker.
// ----------------------------------------------------------------------------
`ifndef LU_LINEAR_SOLVER_ASSERT_SVH
`define LU_LINEAR_SOLVER_ASSERT_SVH

// same-cycle implication
`define LU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lu solver check failed");

// next-cycle implication
`define LU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lu solver check failed");

`endif

// ===== hw/rtl/lu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_pkg
// Types, codes and fixed-point helpers of the LU solver.
// ----------------------------------------------------------------------------
package lu_pkg;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_SOLVE  = 2'd2;

    localparam logic [1:0] CFG_ORDER  = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;

    localparam int ROW_SPAN = 16;
    localparam logic [4:0]  ORDER_RESET  = 5'd10;
    localparam logic [24:0] THRESH_RESET = 25'd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               status;
        logic               last;
    } t_rsp;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] q;
    } t_div_rsp;

    function automatic logic signed [31:0] f_sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -48'sh0000_8000_0000) r = -32'sh8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    // Q8.24 product rounding, half toward plus infinity
    function automatic logic signed [39:0] f_rnd(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd8388608;
        return t[63:24];
    endfunction

endpackage

// ===== hw/rtl/lu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_cell
// One stage of the pivot-row ring; passes its word on when shifted.
// ----------------------------------------------------------------------------
module lu_cell (
    input  logic               i_clk,
    input  logic               i_shift,
    input  logic signed [31:0] i_d,
    output logic signed [31:0] o_q
);

    logic signed [31:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ===== hw/rtl/lu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_div
// Q8.24 divider: (num << 24) / den, truncated, saturated. Radix 2.
// ----------------------------------------------------------------------------
module lu_div
    import lu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int DW = 56;
    localparam int NW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [NW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [DW-1:0] r_dd;
    logic [31:0]   r_dv;
    logic          r_neg;
    logic signed [31:0] r_q;

    logic [32:0]   trial;
    logic          ge;
    logic [32:0]   n_rem;
    logic [DW-1:0] n_dd;
    logic [31:0]   num_mag;
    logic [31:0]   den_mag;
    logic signed [31:0] q_sat;

    assign num_mag = i_req.num[31] ? (32'd0 - i_req.num) : i_req.num;
    assign den_mag = i_req.den[31] ? (32'd0 - i_req.den) : i_req.den;
    assign trial   = {r_rem, r_dd[DW-1]};
    assign ge      = trial >= {1'b0, r_dv};
    assign n_rem   = ge ? (trial - {1'b0, r_dv}) : trial;
    assign n_dd    = {r_dd[DW-2:0], ge};

    always_comb begin
        if (r_neg) begin
            if (n_dd > DW'(64'h8000_0000)) q_sat = -32'sh8000_0000;
            else q_sat = 32'd0 - n_dd[31:0];
        end else begin
            if (n_dd > DW'(64'h7FFF_FFFF)) q_sat = 32'sh7FFF_FFFF;
            else q_sat = n_dd[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dd   <= {num_mag, 24'd0};
                r_dv   <= den_mag;
                r_neg  <= i_req.num[31] ^ i_req.den[31];
            end else if (r_busy) begin
                r_rem <= n_rem[31:0];
                r_dd  <= n_dd;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_q    <= q_sat;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

// ===== hw/rtl/lu_linear_solver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_linear_solver
// Doolittle LU factorization without pivoting and triangular solve, Q8.24.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when i_start is high and o_busy is low. Loads of A
//   (by row and column) and of B (by row) leave o_busy low.
//   A solve request raises o_busy until its last result has been shown.
//   Results appear on o_rsp with o_rsp_valid for one cycle each, in index
//   order, the last one flagged; a small pivot gives one result with status
//   set instead. The receiver cannot stall; results come on consecutive cycles.
//   Solve steps: copy of A into the working matrix, then per pivot k a ring
//   load of the pivot row plus, per row below it, one divide and a pass of
//   the ring; substitution takes one multiply-accumulate per product and
//   one divide per entry. The serial divider and the single working-matrix
//   read port set the pace of these steps.
//   The pivot row sits in a ring of cells rotating past a shared multiplier.
//   Configuration writes (index 0 order, 1 pivot threshold) are always ready.
//   Reset sets order 10 and threshold 1; store contents are undefined.
// ----------------------------------------------------------------------------
module lu_linear_solver
    import lu_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_req        i_req,
    output logic        o_busy,
    output logic        o_rsp_valid,
    output t_rsp        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int LIM   = (MAX_ORDER < ROW_SPAN) ? MAX_ORDER : ROW_SPAN;
    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(LIM + 1);
    localparam int YW    = $clog2(LIM);
    localparam int IW    = $clog2(MAX_ORDER);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_COPY = 5'd1;
    localparam logic [4:0] S_KLD  = 5'd2;
    localparam logic [4:0] S_KLDD = 5'd3;
    localparam logic [4:0] S_PIV  = 5'd4;
    localparam logic [4:0] S_ERR  = 5'd5;
    localparam logic [4:0] S_EIK  = 5'd6;
    localparam logic [4:0] S_EDS  = 5'd7;
    localparam logic [4:0] S_EDW  = 5'd8;
    localparam logic [4:0] S_EJ   = 5'd9;
    localparam logic [4:0] S_EJM  = 5'd10;
    localparam logic [4:0] S_EJW  = 5'd11;
    localparam logic [4:0] S_FI   = 5'd12;
    localparam logic [4:0] S_FA   = 5'd13;
    localparam logic [4:0] S_FM   = 5'd14;
    localparam logic [4:0] S_FC   = 5'd15;
    localparam logic [4:0] S_BI   = 5'd16;
    localparam logic [4:0] S_BA   = 5'd17;
    localparam logic [4:0] S_BM   = 5'd18;
    localparam logic [4:0] S_BC   = 5'd19;
    localparam logic [4:0] S_BDA  = 5'd20;
    localparam logic [4:0] S_BDS  = 5'd21;
    localparam logic [4:0] S_BDW  = 5'd22;
    localparam logic [4:0] S_OUT  = 5'd23;

    function automatic logic [AW-1:0] f_addr(input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
        return AW'(r * MAX_ORDER + c);
    endfunction

    logic [4:0]         r_state;
    logic [4:0]         r_order;
    logic [24:0]        r_thr;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_j;
    logic [AW:0]        r_cnt;
    logic signed [31:0] r_f;
    logic signed [31:0] r_piv;
    logic signed [31:0] r_a;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_acc;
    logic signed [31:0] r_mdata;
    logic signed [31:0] r_udata;

    logic signed [31:0] mstore [DEPTH];
    logic signed [31:0] umem   [DEPTH];
    logic signed [31:0] r_b    [MAX_ORDER];
    logic signed [31:0] r_y    [LIM];

    logic [AW-1:0]      u_raddr;
    logic               u_we;
    logic [AW-1:0]      u_waddr;
    logic signed [31:0] u_wdata;
    logic               w_shift;
    logic               w_load;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [31:0] w_cell [LIM];
    logic signed [31:0] head;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic               acc_ok;
    logic               j_last;
    logic               j_in;
    logic [32:0]        piv_ext;
    logic [32:0]        piv_mag;
    logic signed [39:0] rp;
    logic signed [47:0] ev;
    logic signed [47:0] fy;
    logic signed [47:0] bv;
    logic signed [31:0] bi;
    logic signed [31:0] yi;
    logic [CW-1:0]      n_n;

    assign acc_ok = i_start && !o_busy;
    assign head   = w_cell[0];
    assign j_last = (r_j == CW'(LIM - 1));
    assign j_in   = (r_j > r_k) && (r_j < r_n);
    assign piv_ext = {r_piv[31], r_piv};
    assign piv_mag = r_piv[31] ? (33'd0 - piv_ext) : piv_ext;
    assign rp     = f_rnd(r_prod);
    assign bi     = r_b[IW'(r_i)];
    assign yi     = r_y[YW'(r_i)];
    assign ev     = $signed({{16{r_a[31]}}, r_a}) - $signed({{8{rp[39]}}, rp});
    assign fy     = $signed({{16{bi[31]}}, bi}) - r_acc;
    assign bv     = $signed({{16{yi[31]}}, yi}) - r_acc;

    always_comb begin
        if (r_order < 5'd2) n_n = CW'(2);
        else if (r_order > 5'(LIM)) n_n = CW'(LIM);
        else n_n = CW'(r_order);
    end

    // pivot-row ring
    for (genvar c = 0; c < LIM; c++) begin : g_ring
        logic signed [31:0] d;
        if (c == LIM - 1) begin : g_tail
            assign d = w_load ? r_udata : w_cell[0];
        end else begin : g_mid
            assign d = w_cell[c + 1];
        end
        lu_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_d     (d),
            .o_q     (w_cell[c])
        );
    end

    lu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        u_raddr       = f_addr(r_i, r_j);
        u_we          = 1'b0;
        u_waddr       = f_addr(r_i, r_j);
        u_wdata       = ev[31:0];
        w_shift       = 1'b0;
        w_load        = 1'b0;
        mul_a         = r_udata;
        mul_b         = r_y[YW'(r_j)];
        div_req.start = 1'b0;
        div_req.num   = r_udata;
        div_req.den   = r_piv;
        unique case (r_state)
            S_COPY: begin
                u_we    = (r_cnt != '0);
                u_waddr = AW'(r_cnt - 1'b1);
                u_wdata = r_mdata;
            end
            S_KLD: u_raddr = f_addr(r_k, r_j);
            S_KLDD: begin
                w_shift = 1'b1;
                w_load  = 1'b1;
            end
            S_EIK: u_raddr = f_addr(r_i, r_k);
            S_EDS: div_req.start = 1'b1;
            S_EDW: begin
                u_we    = div_rsp.done;
                u_waddr = f_addr(r_i, r_k);
                u_wdata = div_rsp.q;
            end
            S_EJ: w_shift = !j_in;
            S_EJM: begin
                mul_a = r_f;
                mul_b = head;
            end
            S_EJW: begin
                u_we    = 1'b1;
                u_wdata = f_sat32(ev);
                w_shift = 1'b1;
            end
            S_BDA: u_raddr = f_addr(r_i, r_i);
            S_BDS: begin
                div_req.start = 1'b1;
                div_req.num   = f_sat32(bv);
                div_req.den   = r_udata;
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (acc_ok && i_req.req_type == REQ_LOAD_A && i_req.row < MAX_ORDER
            && i_req.col < MAX_ORDER) begin
            mstore[AW'(i_req.row * MAX_ORDER + i_req.col)] <= i_req.value;
        end
        r_mdata <= mstore[AW'(r_cnt)];
    end

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            umem[u_waddr] <= u_wdata;
        end
        r_udata <= umem[u_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_ok && i_req.req_type == REQ_LOAD_B && i_req.row < MAX_ORDER) begin
            r_b[IW'(i_req.row)] <= i_req.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_thr   <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORDER:  r_order <= i_cfg_data[4:0];
                CFG_THRESH: r_thr   <= i_cfg_data[24:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc_ok && i_req.req_type == REQ_SOLVE) begin
                        r_n     <= n_n;
                        r_cnt   <= '0;
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (r_cnt == (AW + 1)'(DEPTH)) begin
                        r_k     <= '0;
                        r_j     <= '0;
                        r_state <= S_KLD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_KLD: r_state <= S_KLDD;
                S_KLDD: begin
                    if (r_j == r_k) r_piv <= r_udata;
                    if (j_last) begin
                        r_j     <= '0;
                        r_state <= S_PIV;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_KLD;
                    end
                end
                S_PIV: begin
                    if (r_piv == 32'sd0 || piv_mag < {8'd0, r_thr}) begin
                        r_state <= S_ERR;
                    end else if (r_k == r_n - 1'b1) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= S_FI;
                    end else begin
                        r_i     <= r_k + 1'b1;
                        r_state <= S_EIK;
                    end
                end
                S_ERR: r_state <= S_IDLE;
                S_EIK: r_state <= S_EDS;
                S_EDS: r_state <= S_EDW;
                S_EDW: begin
                    if (div_rsp.done) begin
                        r_f     <= div_rsp.q;
                        r_j     <= '0;
                        r_state <= S_EJ;
                    end
                end
                S_EJ, S_EJW: begin
                    if (r_state == S_EJ && j_in) begin
                        r_state <= S_EJM;
                    end else if (j_last) begin
                        r_j <= '0;
                        if (r_i == r_n - 1'b1) begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_KLD;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_EIK;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_EJ;
                    end
                end
                S_EJM: begin
                    r_a     <= r_udata;
                    r_state <= S_EJW;
                end
                S_FI: begin
                    if (r_j == r_i) begin
                        r_y[YW'(r_i)] <= f_sat32(fy);
                        r_acc <= '0;
                        if (r_i == r_n - 1'b1) begin
                            r_j     <= r_n;
                            r_state <= S_BI;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_j <= '0;
                        end
                    end else begin
                        r_state <= S_FA;
                    end
                end
                S_FA: r_state <= S_FM;
                S_FM: r_state <= S_FC;
                S_FC: begin
                    r_acc   <= r_acc + $signed({{8{rp[39]}}, rp});
                    r_j     <= r_j + 1'b1;
                    r_state <= S_FI;
                end
                S_BI: r_state <= (r_j == r_n) ? S_BDA : S_BA;
                S_BA: r_state <= S_BM;
                S_BM: r_state <= S_BC;
                S_BC: begin
                    r_acc   <= r_acc + $signed({{8{rp[39]}}, rp});
                    r_j     <= r_j + 1'b1;
                    r_state <= S_BI;
                end
                S_BDA: r_state <= S_BDS;
                S_BDS: r_state <= S_BDW;
                S_BDW: begin
                    if (div_rsp.done) begin
                        r_y[YW'(r_i)] <= div_rsp.q;
                        r_acc <= '0;
                        if (r_i == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_j     <= r_i;
                            r_i     <= r_i - 1'b1;
                            r_state <= S_BI;
                        end
                    end
                end
                S_OUT: begin
                    if (r_i == r_n - 1'b1) r_state <= S_IDLE;
                    else r_i <= r_i + 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = (r_state == S_ERR) || (r_state == S_OUT);

    always_comb begin
        if (r_state == S_ERR) begin
            o_rsp.index    = 4'(r_k);
            o_rsp.solution = 32'sd0;
            o_rsp.status   = 1'b1;
            o_rsp.last     = 1'b1;
        end else begin
            o_rsp.index    = 4'(r_i);
            o_rsp.solution = yi;
            o_rsp.status   = 1'b0;
            o_rsp.last     = (r_i == r_n - 1'b1);
        end
    end

endmodule

// ===== hw/rtl/lu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_chk
// Port-level checks of the LU solver busy flag and result stream.
// ----------------------------------------------------------------------------
`include "lu_linear_solver_assert.svh"

module lu_chk
    import lu_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input t_req i_req,
    input logic o_busy,
    input logic o_rsp_valid,
    input t_rsp o_rsp
);

    `LU_ASSERT_IMP(a_rsp_busy, i_clk, i_rst_n, o_rsp_valid, o_busy)
    `LU_ASSERT_NXT(a_solve_busy, i_clk, i_rst_n, i_start && !o_busy && i_req.req_type == REQ_SOLVE, o_busy)
    `LU_ASSERT_NXT(a_last_ends, i_clk, i_rst_n, o_rsp_valid && o_rsp.last, !o_rsp_valid)
    `LU_ASSERT_NXT(a_burst, i_clk, i_rst_n, o_rsp_valid && !o_rsp.last, o_rsp_valid)
    `LU_ASSERT_IMP(a_err_last, i_clk, i_rst_n, o_rsp_valid && o_rsp.status, o_rsp.last)

endmodule

bind lu_linear_solver lu_chk u_chk (.*);
